@@ rtl/tpes_pkg.sv @@
// ---------------------------------------------------------------------------
// tpes_pkg
// Shared types and constants for the three-phase power/energy split block.
// ---------------------------------------------------------------------------
package tpes_pkg;

  localparam int VOLT_W  = 13;
  localparam int CURR_W  = 16;
  localparam int VI_W    = 29;   // voltage * current
  localparam int WSUM_W  = 31;   // sum of three products
  localparam int POWER_W = 20;
  localparam int FIELD_W = 40;   // energy field width at the ports
  localparam int PC_W    = 2;
  localparam int NPH     = 3;

  localparam logic [PC_W-1:0] PHASES_THREE = 2'd3;
  localparam logic [PC_W-1:0] PHASES_TWO   = 2'd2;

  // register indexes on the config port
  localparam logic [1:0] REG_PHASE_COUNT = 2'd0;
  localparam logic [1:0] REG_SAVED_L1    = 2'd1;
  localparam logic [1:0] REG_SAVED_L2    = 2'd2;
  localparam logic [1:0] REG_SAVED_L3    = 2'd3;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_PREP   = 5'b00010,
    S_LAUNCH = 5'b00100,
    S_WAIT   = 5'b01000,
    S_FIN    = 5'b10000
  } seq_state_t;

  typedef enum logic [2:0] {
    OP_POWER = 3'b001,
    OP_BASE  = 3'b010,
    OP_INC   = 3'b100
  } op_t;

  typedef enum logic [2:0] {
    MD_IDLE = 3'b001,
    MD_MUL  = 3'b010,
    MD_DIV  = 3'b100
  } md_state_t;

endpackage

@@ rtl/tpes_muldiv.sv @@
// ---------------------------------------------------------------------------
// tpes_muldiv
// Bit-serial floor(a * b / d): shift-add multiply, then restoring divide.
// ---------------------------------------------------------------------------
module tpes_muldiv #(
  parameter int OPW = 40,
  parameter int DW  = 42
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  logic [OPW-1:0] a,
  input  logic [OPW-1:0] b,
  input  logic [DW-1:0]  d,
  output logic           done,
  output logic [OPW-1:0] q
);

  localparam int CW = $clog2(2*OPW+1);

  tpes_pkg::md_state_t st_r, st_nxt;
  logic [CW-1:0]  cnt_r;
  logic [OPW-1:0] mcand_r;
  logic [OPW-1:0] acc_r;
  logic [OPW-1:0] mlo_r;   // multiplier, product low half, then quotient
  logic [DW-1:0]  d_r;
  logic [DW-1:0]  rem_r;
  logic           done_r;

  logic [OPW:0]   madd;
  logic [DW:0]    sh;
  logic           ge;

  assign madd = {1'b0, acc_r} + (mlo_r[0] ? {1'b0, mcand_r} : '0);
  assign sh   = {rem_r, acc_r[OPW-1]};
  assign ge   = (sh >= {1'b0, d_r});

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      tpes_pkg::MD_IDLE: if (start) st_nxt = tpes_pkg::MD_MUL;
      tpes_pkg::MD_MUL:  if (cnt_r == CW'(OPW-1)) st_nxt = tpes_pkg::MD_DIV;
      tpes_pkg::MD_DIV:  if (cnt_r == CW'(2*OPW-1)) st_nxt = tpes_pkg::MD_IDLE;
      default:           st_nxt = tpes_pkg::MD_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= tpes_pkg::MD_IDLE;
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= (st_r == tpes_pkg::MD_DIV) && (cnt_r == CW'(2*OPW-1));
      if (st_r != st_nxt) cnt_r <= '0;
      else if (st_r != tpes_pkg::MD_IDLE) cnt_r <= cnt_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      tpes_pkg::MD_IDLE: begin
        if (start) begin
          mcand_r <= a;
          mlo_r   <= b;
          acc_r   <= '0;
          d_r     <= d;
          rem_r   <= '0;
        end
      end
      tpes_pkg::MD_MUL: begin
        // LSB-first: product low bits shift into the multiplier register
        acc_r <= madd[OPW:1];
        mlo_r <= {madd[0], mlo_r[OPW-1:1]};
      end
      tpes_pkg::MD_DIV: begin
        rem_r <= ge ? DW'(sh - {1'b0, d_r}) : sh[DW-1:0];
        acc_r <= {acc_r[OPW-2:0], mlo_r[OPW-1]};
        mlo_r <= {mlo_r[OPW-2:0], ge};
      end
      default: begin
        rem_r <= rem_r;
      end
    endcase
  end

  assign done = done_r;
  assign q    = (d_r == '0) ? '0 : mlo_r;

endmodule

@@ rtl/three_phase_power_energy_split.sv @@
// ---------------------------------------------------------------------------
// three_phase_power_energy_split
// Splits total power and lifetime energy of a three-phase source per phase.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall): one item = three phase voltages and
//   currents, total power and total energy. Result channel
//   (out_valid/out_stall): per-phase power and per-phase energy counters.
//   Config is an APB-style port, 64-bit data, register i at byte 8*i:
//   phase_count, saved_energy_l1..l3. Write only while idle.
// Sequence:
//   One item at a time. Per item: accept, form the V*I weights and the share
//   sum, then three serial mul-div operations per phase in use (operand
//   width OPW = max(ENERGY_BITS,32)), then the output register. All mul-div
//   operations run on the single bit-serial mul-div.
// Reset: counters unset, no previous total, phase_count = 3, saved = 0.
//   No clearing pass.
// Stall: a finished result waits in the output register; the sequencer holds
//   before its final step until that register is free. in_stall is high
//   whenever an item is in progress.
// ---------------------------------------------------------------------------
module three_phase_power_energy_split #(
  parameter int ENERGY_BITS = 40
) (
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [12:0] in_voltage_l1,
  input  logic [12:0] in_voltage_l2,
  input  logic [12:0] in_voltage_l3,
  input  logic [15:0] in_current_l1,
  input  logic [15:0] in_current_l2,
  input  logic [15:0] in_current_l3,
  input  logic [19:0] in_total_power,
  input  logic [39:0] in_total_energy,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [19:0] out_power_l1,
  output logic [19:0] out_power_l2,
  output logic [19:0] out_power_l3,
  output logic [39:0] out_energy_l1,
  output logic [39:0] out_energy_l2,
  output logic [39:0] out_energy_l3,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int E      = ENERGY_BITS;
  localparam int OPW    = (E > 32) ? E : 32;          // mul-div operand width
  localparam int DW_RAW = (E + 2 > 64) ? 64 : E + 2;  // share sum, capped at 64 bits
  localparam int DW     = (DW_RAW < tpes_pkg::WSUM_W) ? tpes_pkg::WSUM_W : DW_RAW;

  // ---------------- configuration ----------------
  logic [tpes_pkg::PC_W-1:0] pc_r;
  logic [E-1:0]              saved_r [tpes_pkg::NPH];
  logic                      cfg_wr;
  logic [1:0]                cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= tpes_pkg::PHASES_THREE;
      for (int i = 0; i < tpes_pkg::NPH; i++) saved_r[i] <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        tpes_pkg::REG_PHASE_COUNT: pc_r <= pwdata[tpes_pkg::PC_W-1:0];
        tpes_pkg::REG_SAVED_L1:    saved_r[0] <= E'(pwdata[tpes_pkg::FIELD_W-1:0]);
        tpes_pkg::REG_SAVED_L2:    saved_r[1] <= E'(pwdata[tpes_pkg::FIELD_W-1:0]);
        tpes_pkg::REG_SAVED_L3:    saved_r[2] <= E'(pwdata[tpes_pkg::FIELD_W-1:0]);
        default:                   pc_r <= pc_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      tpes_pkg::REG_PHASE_COUNT: prdata = 64'(pc_r);
      tpes_pkg::REG_SAVED_L1:    prdata = 64'(saved_r[0]);
      tpes_pkg::REG_SAVED_L2:    prdata = 64'(saved_r[1]);
      tpes_pkg::REG_SAVED_L3:    prdata = 64'(saved_r[2]);
      default:                   prdata = '0;
    endcase
  end

  // ---------------- item and block state ----------------
  tpes_pkg::seq_state_t st_r;
  tpes_pkg::op_t        op_r;
  logic [1:0]           k_r;

  logic [tpes_pkg::VOLT_W-1:0]   v_r   [tpes_pkg::NPH];
  logic [tpes_pkg::CURR_W-1:0]   c_r   [tpes_pkg::NPH];
  logic [tpes_pkg::VI_W-1:0]     vi_r  [tpes_pkg::NPH];
  logic [tpes_pkg::POWER_W-1:0]  pwr_r [tpes_pkg::NPH];
  logic [tpes_pkg::POWER_W-1:0]  tp_r;
  logic [E-1:0]                  te_r;
  logic [tpes_pkg::WSUM_W-1:0]   w_r;
  logic [DW-1:0]                 a_r;
  logic [E-1:0]                  base_r;

  logic [E-1:0] prev_r;
  logic         prev_known_r;
  logic [E-1:0] pe_r  [tpes_pkg::NPH];
  logic         pek_r [tpes_pkg::NPH];

  // output register
  logic                         out_valid_r;
  logic [tpes_pkg::POWER_W-1:0] opwr_r [tpes_pkg::NPH];
  logic [tpes_pkg::FIELD_W-1:0] oen_r  [tpes_pkg::NPH];

  // ---------------- combinational helpers ----------------
  logic [E-1:0]               eff [tpes_pkg::NPH];
  logic [tpes_pkg::PC_W-1:0]  phases;
  logic [1:0]                 last_k;
  logic [E-1:0]               delta;
  logic [tpes_pkg::VI_W-1:0]  vi_prod;
  logic [DW:0]                a_sum;
  logic                       in_use;
  logic                       in_acc;
  logic                       fin_go;

  // a counter that holds zero counts as unset
  always_comb begin
    for (int i = 0; i < tpes_pkg::NPH; i++)
      eff[i] = (pek_r[i] && (pe_r[i] != '0)) ? pe_r[i] : saved_r[i];
  end

  assign phases  = (pc_r == tpes_pkg::PHASES_THREE) ? tpes_pkg::PHASES_THREE
                                                    : tpes_pkg::PHASES_TWO;
  assign last_k  = phases - 2'd1;
  assign delta   = (te_r > prev_r) ? (te_r - prev_r) : '0;
  assign vi_prod = tpes_pkg::VI_W'(v_r[k_r] * c_r[k_r]);
  assign a_sum   = {1'b0, a_r} + (DW+1)'(eff[k_r]);
  assign in_use  = (k_r <= last_k);
  assign in_acc  = in_valid && !in_stall;
  assign fin_go  = (st_r == tpes_pkg::S_FIN) && (!out_valid_r || !out_stall);

  // ---------------- mul-div operand select ----------------
  logic           md_start;
  logic [OPW-1:0] md_a, md_b;
  logic [DW-1:0]  md_d;
  logic           md_done;
  logic [OPW-1:0] md_q;

  assign md_start = (st_r == tpes_pkg::S_LAUNCH);

  always_comb begin
    md_a = OPW'(tp_r);
    md_b = OPW'(vi_r[k_r]);
    md_d = DW'(w_r);
    case (op_r)
      tpes_pkg::OP_POWER: begin
        md_a = OPW'(tp_r);
      end
      tpes_pkg::OP_BASE: begin
        md_a = OPW'(prev_r);
        if (a_r != '0) begin
          md_b = OPW'(eff[k_r]);
          md_d = a_r;
        end else begin
          // no stored share: split the previous total evenly
          md_b = OPW'(1);
          md_d = DW'(phases);
        end
      end
      tpes_pkg::OP_INC: begin
        md_a = OPW'(delta);
      end
      default: begin
        md_a = '0;
      end
    endcase
  end

  tpes_muldiv #(
    .OPW (OPW),
    .DW  (DW)
  ) u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start),
    .a     (md_a),
    .b     (md_b),
    .d     (md_d),
    .done  (md_done),
    .q     (md_q)
  );

  // new counter value, clamped to the counter width
  logic [E:0]   e_sum;
  logic [E-1:0] e_new;
  assign e_sum = {1'b0, base_r} + (E+1)'(md_q);
  assign e_new = e_sum[E] ? '1 : e_sum[E-1:0];

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= tpes_pkg::S_IDLE;
      op_r         <= tpes_pkg::OP_POWER;
      k_r          <= '0;
      prev_known_r <= 1'b0;
      prev_r       <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < tpes_pkg::NPH; i++) begin
        pe_r[i]  <= '0;
        pek_r[i] <= 1'b0;
      end
    end else begin
      if (fin_go) out_valid_r <= 1'b1;
      else if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (st_r)
        tpes_pkg::S_IDLE: begin
          if (in_acc) begin
            st_r <= tpes_pkg::S_PREP;
            k_r  <= '0;
          end
        end
        tpes_pkg::S_PREP: begin
          if (k_r == 2'd2) begin
            st_r <= tpes_pkg::S_LAUNCH;
            op_r <= tpes_pkg::OP_POWER;
            k_r  <= '0;
          end else begin
            k_r <= k_r + 2'd1;
          end
        end
        tpes_pkg::S_LAUNCH: begin
          st_r <= tpes_pkg::S_WAIT;
        end
        tpes_pkg::S_WAIT: begin
          if (md_done) begin
            if ((op_r == tpes_pkg::OP_INC) && (k_r == last_k)) st_r <= tpes_pkg::S_FIN;
            else st_r <= tpes_pkg::S_LAUNCH;
            case (op_r)
              tpes_pkg::OP_POWER: op_r <= tpes_pkg::OP_BASE;
              tpes_pkg::OP_BASE:  op_r <= tpes_pkg::OP_INC;
              tpes_pkg::OP_INC: begin
                op_r <= tpes_pkg::OP_POWER;
                if (prev_known_r) begin
                  pe_r[k_r]  <= e_new;
                  pek_r[k_r] <= 1'b1;
                end
                if (k_r != last_k) k_r <= k_r + 2'd1;
              end
              default: op_r <= tpes_pkg::OP_POWER;
            endcase
          end
        end
        tpes_pkg::S_FIN: begin
          if (fin_go) begin
            prev_r       <= te_r;
            prev_known_r <= 1'b1;
            st_r         <= tpes_pkg::S_IDLE;
          end
        end
        default: st_r <= tpes_pkg::S_IDLE;
      endcase
    end
  end

  // ---------------- datapath registers ----------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      v_r[0] <= in_voltage_l1;
      v_r[1] <= in_voltage_l2;
      v_r[2] <= in_voltage_l3;
      c_r[0] <= in_current_l1;
      c_r[1] <= in_current_l2;
      c_r[2] <= in_current_l3;
      tp_r   <= in_total_power;
      te_r   <= E'(in_total_energy);
      w_r    <= '0;
      a_r    <= '0;
      for (int i = 0; i < tpes_pkg::NPH; i++) pwr_r[i] <= '0;
    end
    if (st_r == tpes_pkg::S_PREP) begin
      vi_r[k_r] <= vi_prod;
      if (in_use) begin
        w_r <= w_r + tpes_pkg::WSUM_W'(vi_prod);
        a_r <= a_sum[DW] ? '1 : a_sum[DW-1:0];
      end
    end
    if ((st_r == tpes_pkg::S_WAIT) && md_done) begin
      if (op_r == tpes_pkg::OP_POWER) pwr_r[k_r] <= md_q[tpes_pkg::POWER_W-1:0];
      if (op_r == tpes_pkg::OP_BASE)  base_r     <= E'(md_q);
    end
    if (fin_go) begin
      for (int i = 0; i < tpes_pkg::NPH; i++) begin
        opwr_r[i] <= pwr_r[i];
        oen_r[i]  <= tpes_pkg::FIELD_W'(eff[i]);
      end
    end
  end

  // ---------------- ports ----------------
  assign in_stall      = (st_r != tpes_pkg::S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_power_l1  = opwr_r[0];
  assign out_power_l2  = opwr_r[1];
  assign out_power_l3  = opwr_r[2];
  assign out_energy_l1 = oen_r[0];
  assign out_energy_l2 = oen_r[1];
  assign out_energy_l3 = oen_r[2];

endmodule
